[hdl/olt_pkg.sv]
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and codes for the ordered list table: operation and status
// codes, walk modes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package olt_pkg;

	// Fixed field widths of the request and response payloads
	localparam int OP_W     = 3;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 6;
	localparam int CNT_W    = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_DELETE = 3'd3,
		OP_CLEAR  = 3'd4
	} olt_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD     = 2'd2,
		STAT_MISSING = 2'd3
	} olt_status_t;

	// What the shared walk unit does with each element read back
	typedef enum logic [1:0] {
		MODE_SCAN = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} olt_mode_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_PUT  = 4'b0100,
		S_DONE = 4'b1000
	} olt_state_t;

	// Status from the walk unit back to the sequencer
	typedef struct packed {
		logic hit;
		logic last_issue;
	} olt_walk_flags_t;

endpackage

[hdl/olt_if.sv]
// ----------------------------------------------------------------------------
// olt_if
// Valid/ready channels of the ordered list table: request and response.
// ----------------------------------------------------------------------------
interface olt_req_if import olt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [POS_W-1:0] position;
	logic [VAL_W-1:0]        value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface olt_rsp_if import olt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FIDX_W-1:0]   found_index;
	logic [CNT_W-1:0]    count;

	modport source (output valid, output status, output found_index, output count, input ready);
	modport sink   (input valid, input status, input found_index, input count, output ready);
endinterface

[hdl/olt_store.sv]
// ----------------------------------------------------------------------------
// olt_store
// Element storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module olt_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int EW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data
);

	logic [EW-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/olt_walk_unit.sv]
// ----------------------------------------------------------------------------
// olt_walk_unit
// Shared step unit: compares the element read back against the key, steps
// the read address and forms the move target of the element in flight.
// ----------------------------------------------------------------------------
module olt_walk_unit import olt_pkg::*; #(
	parameter int AW = 6,
	parameter int EW = 32
) (
	input  olt_mode_t       mode,
	input  logic [AW-1:0]   cur,
	input  logic [AW-1:0]   lst,
	input  logic [AW-1:0]   addr_s1,
	input  logic [EW-1:0]   rd_data,
	input  logic [EW-1:0]   key,
	output logic [AW-1:0]   cur_nxt,
	output logic [AW-1:0]   step_addr,
	output olt_walk_flags_t flags
);

	// Walk downward only while opening a gap, upward otherwise
	always_comb begin
		case (mode)
			MODE_UP: begin
				cur_nxt   = cur - AW'(1);
				step_addr = addr_s1 + AW'(1);
			end
			MODE_DOWN: begin
				cur_nxt   = cur + AW'(1);
				step_addr = addr_s1 - AW'(1);
			end
			default: begin
				cur_nxt   = cur + AW'(1);
				step_addr = addr_s1 + AW'(1);
			end
		endcase
	end

	assign flags.hit        = (rd_data == key);
	assign flags.last_issue = (cur == lst);

endmodule

[hdl/ordered_list_table_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Ordered list of up to CAPACITY elements with insert, remove, find, delete
// and clear. One request gives one response with status, index and count.
//
//   channel | dir | transfer payload
//   --------+-----+-------------------------------------------
//   req     | in  | op, position, value
//   rsp     | out | status, found_index, count
//
// A request is taken only in idle. Find and delete read one element per
// cycle through the single storage read port. Insert moves count - position
// elements, remove moves the ones after the position, one per cycle. The
// read port of the element store sets the walk rate.
// Reset empties the list at once through the fill count; no clearing pass.
// A stalled response waits in its output register; the next request is
// still taken, and its result holds until that register is free.
// ----------------------------------------------------------------------------
module ordered_list_table_unit import olt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	olt_req_if.sink   req,
	olt_rsp_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NW = ((CW > POS_W) ? CW : POS_W) + 2;

	olt_state_t            state_q;
	olt_mode_t             mode_q;
	olt_status_t           status_q;
	logic                  del_q;
	logic [ELEM_WIDTH-1:0] key_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         cur_q;
	logic [AW-1:0]         lst_q;
	logic                  iss_q;
	logic                  vld_s1;
	logic [AW-1:0]         addr_s1;
	logic [AW-1:0]         fidx_q;

	logic                  out_vld_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [FIDX_W-1:0]     out_fidx_q;
	logic [CNT_W-1:0]      out_count_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic [AW-1:0]         cur_nxt;
	logic [AW-1:0]         step_addr;
	olt_walk_flags_t       wflags;

	logic [ELEM_WIDTH+VAL_W-1:0] key_wide;
	logic [ELEM_WIDTH-1:0]       key_in;
	logic signed [NW-1:0]        pos_ext;
	logic signed [NW-1:0]        cnt_ext;
	logic signed [NW-1:0]        ins_n;
	logic signed [NW-1:0]        rem_n;
	logic                        ins_bad;
	logic                        rem_bad;
	logic                        full;
	logic [CW-1:0]               cnt_m1;
	logic [AW+FIDX_W-1:0]        fidx_wide;
	logic [CW+CNT_W-1:0]         cnt_wide;

	// Reduce the incoming value to the element width
	assign key_wide = {{ELEM_WIDTH{1'b0}}, req.value};
	assign key_in   = key_wide[ELEM_WIDTH-1:0];

	// Normalize a negative position against the current count
	assign pos_ext = {{(NW-POS_W){req.position[POS_W-1]}}, req.position};
	assign cnt_ext = {{(NW-CW){1'b0}}, count_q};
	assign ins_n   = pos_ext[NW-1] ? (cnt_ext + pos_ext + NW'(1)) : pos_ext;
	assign rem_n   = pos_ext[NW-1] ? (cnt_ext + pos_ext) : pos_ext;
	assign ins_bad = (ins_n < 0) || (ins_n > cnt_ext);
	assign rem_bad = (rem_n < 0) || (rem_n >= cnt_ext);
	assign full    = (count_q == CW'(CAPACITY));
	assign cnt_m1  = count_q - CW'(1);

	// Mask index and count to the response field widths
	assign fidx_wide = {{FIDX_W{1'b0}}, fidx_q};
	assign cnt_wide  = {{CNT_W{1'b0}}, count_q};

	olt_store #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.EW    (ELEM_WIDTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cur_q),
		.rd_data (rd_data)
	);

	olt_walk_unit #(
		.AW (AW),
		.EW (ELEM_WIDTH)
	) u_walk (
		.mode      (mode_q),
		.cur       (cur_q),
		.lst       (lst_q),
		.addr_s1   (addr_s1),
		.rd_data   (rd_data),
		.key       (key_q),
		.cur_nxt   (cur_nxt),
		.step_addr (step_addr),
		.flags     (wflags)
	);

	// Storage port control: moves during the walk, new element in put
	assign rd_en = (state_q == S_WALK) && iss_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = step_addr;
		wr_data = rd_data;
		if ((state_q == S_WALK) && vld_s1 && (mode_q != MODE_SCAN)) begin
			wr_en = 1'b1;
		end
		if (state_q == S_PUT) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = key_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_fidx_q;
	assign rsp.count       = out_count_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_SCAN;
			status_q     <= STAT_OK;
			del_q        <= 1'b0;
			key_q        <= '0;
			pos_q        <= '0;
			count_q      <= '0;
			cur_q        <= '0;
			lst_q        <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			addr_s1      <= '0;
			fidx_q       <= '0;
			out_vld_q    <= 1'b0;
			out_status_q <= '0;
			out_fidx_q   <= '0;
			out_count_q  <= '0;
		end else begin
			// Drop the response once transferred
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						key_q    <= key_in;
						del_q    <= (req.op == OP_DELETE);
						fidx_q   <= '0;
						status_q <= STAT_OK;
						vld_s1   <= 1'b0;
						iss_q    <= 1'b0;
						state_q  <= S_DONE;
						case (req.op)
							OP_INSERT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else if (ins_bad) begin
									status_q <= STAT_BAD;
								end else begin
									pos_q <= ins_n[AW-1:0];
									if (ins_n == cnt_ext) begin
										state_q <= S_PUT;
									end else begin
										// Open a gap from the top down
										mode_q  <= MODE_UP;
										cur_q   <= cnt_m1[AW-1:0];
										lst_q   <= ins_n[AW-1:0];
										iss_q   <= 1'b1;
										state_q <= S_WALK;
									end
								end
							end
							OP_REMOVE: begin
								if (rem_bad) begin
									status_q <= STAT_BAD;
								end else if (rem_n == (cnt_ext - NW'(1))) begin
									count_q <= cnt_m1;
								end else begin
									// Close the gap from the position up
									mode_q  <= MODE_DOWN;
									cur_q   <= rem_n[AW-1:0] + AW'(1);
									lst_q   <= cnt_m1[AW-1:0];
									iss_q   <= 1'b1;
									state_q <= S_WALK;
								end
							end
							OP_FIND, OP_DELETE: begin
								if (count_q == '0) begin
									status_q <= STAT_MISSING;
								end else begin
									mode_q  <= MODE_SCAN;
									cur_q   <= '0;
									lst_q   <= cnt_m1[AW-1:0];
									iss_q   <= 1'b1;
									state_q <= S_WALK;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								status_q <= STAT_BAD;
							end
						endcase
					end
				end

				S_WALK: begin
					// Issue the next read
					if (iss_q) begin
						vld_s1  <= 1'b1;
						addr_s1 <= cur_q;
						cur_q   <= cur_nxt;
						if (wflags.last_issue) begin
							iss_q <= 1'b0;
						end
					end else begin
						vld_s1 <= 1'b0;
					end

					// Handle the element read back
					if (vld_s1) begin
						case (mode_q)
							MODE_SCAN: begin
								if (wflags.hit) begin
									fidx_q <= addr_s1;
									vld_s1 <= 1'b0;
									iss_q  <= 1'b0;
									if (!del_q) begin
										state_q <= S_DONE;
									end else if (addr_s1 == lst_q) begin
										count_q <= cnt_m1;
										state_q <= S_DONE;
									end else begin
										mode_q <= MODE_DOWN;
										cur_q  <= step_addr;
										iss_q  <= 1'b1;
									end
								end else if (!iss_q) begin
									status_q <= STAT_MISSING;
									state_q  <= S_DONE;
								end
							end
							MODE_UP: begin
								if (!iss_q) begin
									state_q <= S_PUT;
								end
							end
							MODE_DOWN: begin
								if (!iss_q) begin
									count_q <= cnt_m1;
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end

				S_DONE: begin
					// Hold until the output register is free
					if (!out_vld_q || rsp.ready) begin
						out_vld_q    <= 1'b1;
						out_status_q <= status_q;
						out_fidx_q   <= fidx_wide[FIDX_W-1:0];
						out_count_q  <= cnt_wide[CNT_W-1:0];
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Reads stay inside the filled part of the list
	a_rd_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (cur_q < count_q))
		else $error("read beyond element count");

	// Writes land at most one past the last element
	a_wr_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr <= count_q))
		else $error("write beyond element count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// A new element is only placed into a list with room
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> !full)
		else $error("insert into a full list");

	// A response only appears from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_DONE))
		else $error("response loaded outside done");

endmodule
